/* rtl/cartesian_to_spherical_macros.svh */
// Assertion macros for the checker file of the cartesian_to_spherical block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CARTESIAN_TO_SPHERICAL_MACROS_SVH
`define CARTESIAN_TO_SPHERICAL_MACROS_SVH

// Checked only while the block is out of reset.
`define C2S_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define C2S_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* rtl/c2s_pkg.sv */
// Shared constants for the cartesian_to_spherical block: default sizes,
// fixed-point formats, the CORDIC gain factor and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

package c2s_pkg;

  localparam int COORD_BITS_DEF    = 24;
  localparam int CORDIC_STAGES_DEF = 24;

  // Fraction bits carried by magnitudes inside the CORDIC rows.
  localparam int MAG_FRAC = 8;
  // Integer headroom on top of a coordinate: sqrt(3) times the CORDIC gain.
  localparam int MAG_GUARD = 3;

  // Angles travel in units of pi/2^31; the longitude can reach about 3*pi/2.
  localparam int ANG_W = 34;

  // Reciprocal CORDIC gain as a fraction of 2^32.
  localparam logic [31:0] INV_GAIN = 32'd2608131496;

  // atan(2^-i) in units of pi/2^31.
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

endpackage

`default_nettype wire

/* rtl/cartesian_to_spherical.sv */
// Cartesian to spherical converter: each request (x, y, z) gives radius, latitude
// asin(z/r) and longitude atan2(y, x), angles in units of pi/2^(COORD_BITS-1).
// A new request is taken every clock cycle while the skid entry is empty. A request
// passes through the input register, the first row of CORDIC micro-rotation cells,
// a gain multiplier, the second row of cells, a second gain multiplier and the output
// register. A stalled output keeps taking requests until the skid entry fills.
// Depends on c2s_pkg, c2s_prep, c2s_cell, c2s_gain and c2s_outq.
`timescale 1ns / 1ps
`default_nettype none

module cartesian_to_spherical #(
  parameter int COORD_BITS    = c2s_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF,
  parameter int TDATA_W       = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // pos_x, pos_y, pos_z, zero fill
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata   // radius, latitude, longitude, zero fill
);

  localparam int CB    = COORD_BITS;
  localparam int N     = CORDIC_STAGES;
  localparam int AW    = c2s_pkg::ANG_W;
  localparam int FRAC  = c2s_pkg::MAG_FRAC;
  localparam int MAG_W = CB + FRAC + c2s_pkg::MAG_GUARD;

  typedef struct packed {
    logic                 polar;
    logic signed [CB-1:0] z;
  } side1_t;

  typedef struct packed {
    logic                 polar;
    logic signed [CB-1:0] z;
    logic signed [AW-1:0] lon;
  } side2_t;

  typedef struct packed {
    logic                 polar;
    logic signed [CB-1:0] z;
    logic signed [AW-1:0] lon;
    logic signed [AW-1:0] lat;
  } side3_t;

  logic                 ce;
  logic signed [CB-1:0] pos_x, pos_y, pos_z;

  logic                    p1_v    [0:N];
  logic signed [MAG_W-1:0] p1_x    [0:N];
  logic signed [MAG_W-1:0] p1_y    [0:N];
  logic signed [AW-1:0]    p1_ang  [0:N];
  side1_t                  p1_side [0:N];
  logic signed [CB-1:0]    prep_z;
  logic                    prep_polar;

  logic                    g1_v;
  logic signed [MAG_W-1:0] g1_p;
  side2_t                  g1_in_side, g1_side;

  logic                    p2_v    [0:N];
  logic signed [MAG_W-1:0] p2_x    [0:N];
  logic signed [MAG_W-1:0] p2_y    [0:N];
  logic signed [AW-1:0]    p2_ang  [0:N];
  side2_t                  p2_side [0:N];

  logic                    g2_v;
  logic signed [MAG_W-1:0] g2_p;
  side3_t                  g2_in_side, g2_side;
  logic [3*CB-1:0]         res_data;

  assign pos_x = in_tdata[CB-1:0];
  assign pos_y = in_tdata[2*CB-1:CB];
  assign pos_z = in_tdata[3*CB-1:2*CB];

  c2s_prep #(
    .COORD_BITS(CB),
    .MAG_W     (MAG_W)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (in_tvalid),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .out_valid(p1_v[0]),
    .out_x    (p1_x[0]),
    .out_y    (p1_y[0]),
    .out_ang  (p1_ang[0]),
    .out_z    (prep_z),
    .out_polar(prep_polar)
  );

  assign p1_side[0] = '{polar: prep_polar, z: prep_z};

  // First row: rotates (x, y) onto the x axis and accumulates the longitude.
  for (genvar g = 0; g < N; g++) begin : g_row1
    c2s_cell #(
      .STAGE (g),
      .MAG_W (MAG_W),
      .SIDE_W($bits(side1_t))
    ) u_p1 (
      .clk      (clk),
      .rst_n    (rst_n),
      .ce       (ce),
      .in_valid (p1_v[g]),
      .in_x     (p1_x[g]),
      .in_y     (p1_y[g]),
      .in_ang   (p1_ang[g]),
      .in_side  (p1_side[g]),
      .out_valid(p1_v[g+1]),
      .out_x    (p1_x[g+1]),
      .out_y    (p1_y[g+1]),
      .out_ang  (p1_ang[g+1]),
      .out_side (p1_side[g+1])
    );
  end

  assign g1_in_side = '{polar: p1_side[N].polar, z: p1_side[N].z, lon: p1_ang[N]};

  c2s_gain #(
    .MAG_W (MAG_W),
    .SIDE_W($bits(side2_t))
  ) u_gain1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (p1_v[N]),
    .in_a     (p1_x[N]),
    .in_side  (g1_in_side),
    .out_valid(g1_v),
    .out_p    (g1_p),
    .out_side (g1_side)
  );

  assign p2_v[0]    = g1_v;
  assign p2_x[0]    = g1_p;
  assign p2_y[0]    = MAG_W'(g1_side.z) <<< FRAC;
  assign p2_ang[0]  = '0;
  assign p2_side[0] = g1_side;

  // Second row: rotates (horizontal distance, z) and accumulates the latitude.
  for (genvar g = 0; g < N; g++) begin : g_row2
    c2s_cell #(
      .STAGE (g),
      .MAG_W (MAG_W),
      .SIDE_W($bits(side2_t))
    ) u_p2 (
      .clk      (clk),
      .rst_n    (rst_n),
      .ce       (ce),
      .in_valid (p2_v[g]),
      .in_x     (p2_x[g]),
      .in_y     (p2_y[g]),
      .in_ang   (p2_ang[g]),
      .in_side  (p2_side[g]),
      .out_valid(p2_v[g+1]),
      .out_x    (p2_x[g+1]),
      .out_y    (p2_y[g+1]),
      .out_ang  (p2_ang[g+1]),
      .out_side (p2_side[g+1])
    );
  end

  assign g2_in_side = '{polar: p2_side[N].polar, z: p2_side[N].z,
                        lon: p2_side[N].lon, lat: p2_ang[N]};

  c2s_gain #(
    .MAG_W (MAG_W),
    .SIDE_W($bits(side3_t))
  ) u_gain2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (p2_v[N]),
    .in_a     (p2_x[N]),
    .in_side  (g2_in_side),
    .out_valid(g2_v),
    .out_p    (g2_p),
    .out_side (g2_side)
  );

  c2s_outq #(
    .COORD_BITS(CB),
    .MAG_W     (MAG_W)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (g2_v),
    .in_polar  (g2_side.polar),
    .in_z      (g2_side.z),
    .in_lon    (g2_side.lon),
    .in_lat    (g2_side.lat),
    .in_r      (g2_p),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_data  (res_data),
    .ce        (ce)
  );

  assign in_tready = ce;
  assign out_tdata = TDATA_W'(res_data);

endmodule

`default_nettype wire

/* rtl/c2s_prep.sv */
// Input stage of the cartesian_to_spherical block: scales the coordinates,
// folds negative x into the right half plane and flags the polar axis. Depends on c2s_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c2s_prep #(
  parameter int COORD_BITS = c2s_pkg::COORD_BITS_DEF,
  parameter int MAG_W      = COORD_BITS + c2s_pkg::MAG_FRAC + c2s_pkg::MAG_GUARD
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ce,
  input  logic                          in_valid,
  input  logic signed [COORD_BITS-1:0]  pos_x,
  input  logic signed [COORD_BITS-1:0]  pos_y,
  input  logic signed [COORD_BITS-1:0]  pos_z,
  output logic                          out_valid,
  output logic signed [MAG_W-1:0]       out_x,
  output logic signed [MAG_W-1:0]       out_y,
  output logic signed [c2s_pkg::ANG_W-1:0] out_ang,
  output logic signed [COORD_BITS-1:0]  out_z,
  output logic                          out_polar
);

  localparam int AW   = c2s_pkg::ANG_W;
  localparam int FRAC = c2s_pkg::MAG_FRAC;
  localparam logic signed [AW-1:0] HALF_TURN = AW'(64'd1 << 31);

  logic                   valid_r;
  logic signed [MAG_W-1:0] x_r, x_nxt;
  logic signed [MAG_W-1:0] y_r, y_nxt;
  logic signed [AW-1:0]    ang_r, ang_nxt;
  logic signed [COORD_BITS-1:0] z_r;
  logic                   polar_r, polar_nxt;
  logic signed [MAG_W-1:0] sx, sy;

  always_comb begin
    sx = MAG_W'(pos_x) <<< FRAC;
    sy = MAG_W'(pos_y) <<< FRAC;
    // A vector in the left half plane is turned by pi before the first row.
    if (pos_x[COORD_BITS-1]) begin
      x_nxt   = -sx;
      y_nxt   = -sy;
      ang_nxt = HALF_TURN;
    end else begin
      x_nxt   = sx;
      y_nxt   = sy;
      ang_nxt = '0;
    end
    polar_nxt = (pos_x == '0) && (pos_y == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ce) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      ang_r   <= ang_nxt;
      z_r     <= pos_z;
      polar_r <= polar_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_ang   = ang_r;
  assign out_z     = z_r;
  assign out_polar = polar_r;

endmodule

`default_nettype wire

/* rtl/c2s_cell.sv */
// One CORDIC vectoring micro-rotation with its pipeline register.
// Depends on c2s_pkg for the angle width and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module c2s_cell #(
  parameter int STAGE  = 0,
  parameter int MAG_W  = 35,
  parameter int SIDE_W = 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             ce,
  input  logic                             in_valid,
  input  logic signed [MAG_W-1:0]          in_x,
  input  logic signed [MAG_W-1:0]          in_y,
  input  logic signed [c2s_pkg::ANG_W-1:0] in_ang,
  input  logic [SIDE_W-1:0]                in_side,
  output logic                             out_valid,
  output logic signed [MAG_W-1:0]          out_x,
  output logic signed [MAG_W-1:0]          out_y,
  output logic signed [c2s_pkg::ANG_W-1:0] out_ang,
  output logic [SIDE_W-1:0]                out_side
);

  localparam int AW = c2s_pkg::ANG_W;
  localparam logic signed [AW-1:0] STEP = AW'(c2s_pkg::ATAN_TAB[STAGE]);

  logic                    valid_r;
  logic signed [MAG_W-1:0] x_r, x_nxt;
  logic signed [MAG_W-1:0] y_r, y_nxt;
  logic signed [AW-1:0]    ang_r, ang_nxt;
  logic [SIDE_W-1:0]       side_r;
  logic signed [MAG_W-1:0] xs, ys;

  always_comb begin
    xs = in_x >>> STAGE;
    ys = in_y >>> STAGE;
    // Rotate toward the x axis; the sign of y picks the direction.
    if (!in_y[MAG_W-1]) begin
      x_nxt   = in_x + ys;
      y_nxt   = in_y - xs;
      ang_nxt = in_ang + STEP;
    end else begin
      x_nxt   = in_x - ys;
      y_nxt   = in_y + xs;
      ang_nxt = in_ang - STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ce) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      ang_r  <= ang_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_ang   = ang_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

/* rtl/c2s_gain.sv */
// Two-stage multiplication by the reciprocal CORDIC gain, rounded half up.
// Depends on c2s_pkg for the gain constant.
`timescale 1ns / 1ps
`default_nettype none

module c2s_gain #(
  parameter int MAG_W  = 35,
  parameter int SIDE_W = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    ce,
  input  logic                    in_valid,
  input  logic signed [MAG_W-1:0] in_a,
  input  logic [SIDE_W-1:0]       in_side,
  output logic                    out_valid,
  output logic signed [MAG_W-1:0] out_p,
  output logic [SIDE_W-1:0]       out_side
);

  localparam int UW    = MAG_W - 1;
  localparam int HW    = UW - 16;
  localparam int PH_W  = HW + 32;
  localparam int SUM_W = UW + 33;

  logic [UW-1:0]        u;
  logic [PH_W-1:0]      phi_r, phi_nxt;
  logic [47:0]          plo_r, plo_nxt;
  logic [SUM_W-1:0]     sum;
  logic signed [MAG_W-1:0] p_r, p_nxt;
  logic                 va_r, vb_r;
  logic [SIDE_W-1:0]    side_a_r, side_b_r;

  // The operand is split at bit 16 so that each product is at most 18 by 32 bits with the default widths.
  always_comb begin
    u       = in_a[MAG_W-1] ? '0 : in_a[UW-1:0];
    phi_nxt = PH_W'(u[UW-1:16]) * PH_W'(c2s_pkg::INV_GAIN);
    plo_nxt = 48'(u[15:0]) * 48'(c2s_pkg::INV_GAIN);
  end

  always_comb begin
    sum   = (SUM_W'(phi_r) << 16) + SUM_W'(plo_r) + SUM_W'(64'h8000_0000);
    p_nxt = MAG_W'(sum >> 32);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (ce) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      phi_r    <= phi_nxt;
      plo_r    <= plo_nxt;
      side_a_r <= in_side;
      p_r      <= p_nxt;
      side_b_r <= side_a_r;
    end
  end

  assign out_valid = vb_r;
  assign out_p     = p_r;
  assign out_side  = side_b_r;

endmodule

`default_nettype wire

/* rtl/c2s_outq.sv */
// Output stage: rounds the results, limits radius and latitude, handles the polar axis,
// and holds them in an output register with a skid entry. Depends on c2s_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c2s_outq #(
  parameter int COORD_BITS = c2s_pkg::COORD_BITS_DEF,
  parameter int MAG_W      = COORD_BITS + c2s_pkg::MAG_FRAC + c2s_pkg::MAG_GUARD
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_polar,
  input  logic signed [COORD_BITS-1:0]     in_z,
  input  logic signed [c2s_pkg::ANG_W-1:0] in_lon,
  input  logic signed [c2s_pkg::ANG_W-1:0] in_lat,
  input  logic signed [MAG_W-1:0]          in_r,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [3*COORD_BITS-1:0]          out_data,
  output logic                             ce
);

  localparam int CB   = COORD_BITS;
  localparam int AW   = c2s_pkg::ANG_W;
  localparam int FRAC = c2s_pkg::MAG_FRAC;
  localparam int SH   = 32 - CB;
  localparam logic signed [AW-1:0] HALF   = AW'((64'd1 << SH) >> 1);
  localparam logic signed [AW-1:0] LAT_Q  = AW'(64'd1 << (CB - 2));
  localparam logic signed [AW-1:0] LAT_QN = -LAT_Q;
  localparam logic [MAG_W:0]       R_RND  = (MAG_W+1)'(64'd1 << (FRAC - 1));

  logic signed [AW-1:0] lon_rnd, lat_rnd, lat_cl;
  logic [MAG_W:0]       rsum;
  logic [CB-1:0]        rad, lat_f, lon_f;
  logic [3*CB-1:0]      res;
  logic                 push, take;
  logic                 out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  logic [3*CB-1:0]      out_d_r, out_d_nxt, skid_d_r, skid_d_nxt;

  always_comb begin
    lon_rnd = (in_lon + HALF) >>> SH;
    lat_rnd = (in_lat + HALF) >>> SH;
    // The CORDIC residue can push the latitude slightly past a pole.
    if (lat_rnd > LAT_Q) begin
      lat_cl = LAT_Q;
    end else if (lat_rnd < LAT_QN) begin
      lat_cl = LAT_QN;
    end else begin
      lat_cl = lat_rnd;
    end
    rsum = (MAG_W+1)'($unsigned(in_r)) + R_RND;
    rad  = (|rsum[MAG_W:FRAC+CB]) ? '1 : rsum[FRAC+CB-1:FRAC];
    lat_f = lat_cl[CB-1:0];
    lon_f = lon_rnd[CB-1:0];
    // On the polar axis the distance is |z| and the latitude is exactly a pole, or zero when z is zero.
    if (in_polar) begin
      rad   = in_z[CB-1] ? CB'(-in_z) : CB'(in_z);
      lon_f = '0;
      if (in_z[CB-1]) begin
        lat_f = LAT_QN[CB-1:0];
      end else if (in_z != '0) begin
        lat_f = LAT_Q[CB-1:0];
      end else begin
        lat_f = '0;
      end
    end
    res = {lon_f, lat_f, rad};
  end

  assign ce   = !skid_v_r;
  assign push = ce && in_valid;
  assign take = out_v_r && out_tready;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (take) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || take) begin
        out_d_nxt = res;
        out_v_nxt = 1'b1;
      end else begin
        skid_d_nxt = res;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_data   = out_d_r;

endmodule

`default_nettype wire

/* rtl/c2s_check.sv */
// Port-level checker for the cartesian_to_spherical block, attached by bind.
// Depends on cartesian_to_spherical_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "cartesian_to_spherical_macros.svh"

module c2s_check #(
  parameter int COORD_BITS = 24,
  parameter int TDATA_W    = 72
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tready,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [TDATA_W-1:0] out_tdata
);

  localparam int CB = COORD_BITS;
  localparam logic signed [CB-1:0] LAT_Q  = CB'(64'd1 << (CB - 2));
  localparam logic signed [CB-1:0] LAT_QN = -LAT_Q;

  logic signed [CB-1:0] lat_w;
  assign lat_w = out_tdata[2*CB-1:CB];

  // Reset empties both output entries and opens the input.
  `C2S_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_tvalid && in_tready, "reset did not clear")

  `C2S_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // Requests are refused only once the output has been held back and the skid filled.
  `C2S_ASSERT(a_ready_cause, $past(rst_n) && !in_tready |-> $past(out_tvalid && !out_tready), "input refused without stall")

  `C2S_ASSERT(a_lat_range, out_tvalid |-> (lat_w <= LAT_Q) && (lat_w >= LAT_QN), "latitude beyond a pole")

endmodule

bind cartesian_to_spherical c2s_check #(
  .COORD_BITS(COORD_BITS),
  .TDATA_W   (TDATA_W)
) u_c2s_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire

/* bench/cartesian_to_spherical_tb.sv */
// Self-checking bench for cartesian_to_spherical: streams 3D positions in and checks
// radius, latitude and longitude against a bit-exact CORDIC predictor held here.
// Depends on c2s_pkg for the default sizes and on the RTL of the block.
`timescale 1ns / 1ps

module cartesian_to_spherical_tb;

  localparam int CB     = c2s_pkg::COORD_BITS_DEF;
  localparam int STAGES = c2s_pkg::CORDIC_STAGES_DEF;
  localparam int TDW    = ((3 * CB + 7) / 8) * 8;
  localparam int FRAC   = 8;
  localparam longint unsigned RECIP_GAIN = 64'd2608131496;
  localparam int N_RANDOM = 730;
  localparam int DRAIN_EVERY = 300;

  // atan(2^-i) in units of pi/2^31.
  localparam logic [31:0] ARCTAN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } pos_t;

  typedef struct packed {
    logic signed [CB-1:0] lon;
    logic signed [CB-1:0] lat;
    logic [CB-1:0]        radius;
  } sph_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_tvalid = 1'b0;
  logic           in_tready;
  logic [TDW-1:0] in_tdata = '0;
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [TDW-1:0] out_tdata;

  pos_t coords_pending [$];
  sph_t spherical_due [$];
  int   req_offered = 0;
  int   req_taken = 0;
  int   send_gap = 0;
  int   sink_stall = 0;
  int   n_directed = 0;
  int   mismatches = 0;
  logic quiet;

  cartesian_to_spherical u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every 250 requests, a stretch of 50 runs with neither side idling.
  assign quiet = (req_offered % 250) >= 200;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Vectoring pass: drives vy toward zero and returns the angle turned in pi/2^31.
  function automatic longint cordic_vector(inout longint vx, inout longint vy);
    longint ang;
    longint sx;
    longint sy;
    ang = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy >= 0) begin
        vx = vx + sy;
        vy = vy - sx;
        ang = ang + longint'(ARCTAN[i]);
      end else begin
        vx = vx - sy;
        vy = vy + sx;
        ang = ang - longint'(ARCTAN[i]);
      end
    end
    return ang;
  endfunction

  // Multiply by the reciprocal gain with rounding half up.
  function automatic longint apply_gain(longint a);
    longint unsigned u;
    longint unsigned hi;
    longint unsigned lo;
    u = (a < 0) ? 64'd0 : longint'(a);
    hi = (u >> 16) * RECIP_GAIN;
    lo = (u & 64'hFFFF) * RECIP_GAIN + 64'h80000000;
    return longint'((hi + (lo >> 16)) >> 16);
  endfunction

  function automatic longint angle_to_port(longint a);
    int s;
    s = 32 - CB;
    if (s == 0) return a;
    return (a + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic sph_t to_spherical(pos_t p);
    longint x;
    longint y;
    longint z;
    longint quarter;
    longint ax;
    longint ay;
    longint bx;
    longint by;
    longint lon;
    longint lat;
    longint r;
    longint unsigned rad;
    longint unsigned mask;
    sph_t res;
    x = p.x;
    y = p.y;
    z = p.z;
    quarter = longint'(1) << (CB - 2);
    mask = (64'd1 << CB) - 1;
    if (x == 0 && y == 0) begin
      // On the polar axis the radius is |z| and the latitude is exactly +-pi/2, or zero when z is zero.
      r = (z < 0) ? -z : z;
      lat = (z > 0) ? quarter : ((z < 0) ? -quarter : 0);
      res.radius = r[CB-1:0];
      res.lat = lat[CB-1:0];
      res.lon = '0;
      return res;
    end
    ax = x * (longint'(1) << FRAC);
    ay = y * (longint'(1) << FRAC);
    lon = 0;
    if (ax < 0) begin
      // Left half plane: turn the vector by pi before the first pass.
      ax = -ax;
      ay = -ay;
      lon = longint'(1) << 31;
    end
    lon = lon + cordic_vector(ax, ay);
    bx = apply_gain(ax);
    by = z * (longint'(1) << FRAC);
    lat = angle_to_port(cordic_vector(bx, by));
    if (lat > quarter) lat = quarter;
    if (lat < -quarter) lat = -quarter;
    r = apply_gain(bx);
    rad = (longint'(r) + (64'd1 << (FRAC - 1))) >> FRAC;
    if (rad > mask) rad = mask;
    lon = angle_to_port(lon);
    res.radius = rad[CB-1:0];
    res.lat = lat[CB-1:0];
    res.lon = lon[CB-1:0];
    return res;
  endfunction

  function automatic coord_t pick_coord(int mode);
    int r;
    r = $urandom_range(0, 5);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 512)) - coord_t'(256);
      2: return coord_t'($urandom_range(0, 6)) - coord_t'(3);
      default: begin
        if (r == 0) return {1'b1, {(CB-1){1'b0}}};
        if (r == 1) return {1'b0, {(CB-1){1'b1}}};
        if (r == 2) return -coord_t'(1);
        if (r == 3) return '0;
        if (r == 4) return coord_t'(1);
        return coord_t'($urandom);
      end
    endcase
  endfunction

  task automatic add_pos(coord_t x, coord_t y, coord_t z);
    pos_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    coords_pending.push_back(p);
  endtask

  // Sender: holds a request until it is taken, then idles for the chosen gap; it also pauses to let results drain.
  always @(negedge clk) begin : feed
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && req_taken != req_offered) begin
      // Still waiting for the current request to be taken.
    end else if (send_gap > 0) begin
      send_gap--;
      in_tvalid <= 1'b0;
    end else if (spherical_due.size() != 0 && req_offered > 0 &&
                 (req_offered == n_directed || req_offered % DRAIN_EVERY == 0)) begin
      in_tvalid <= 1'b0;
    end else if (coords_pending.size() != 0) begin
      in_tdata <= TDW'(coords_pending.pop_front());
      in_tvalid <= 1'b1;
      req_offered++;
      send_gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin : sink
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) sink_stall = idle_len();
    end
  end

  always @(posedge clk) begin : observe
    sph_t got;
    sph_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        spherical_due.push_back(to_spherical(pos_t'(in_tdata[3*CB-1:0])));
        req_taken++;
      end
      if (out_tvalid && out_tready) begin
        got = sph_t'(out_tdata[3*CB-1:0]);
        if (spherical_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing outstanding: r=%0d lat=%0d lon=%0d",
                     $realtime, got.radius, got.lat, got.lon);
        end else begin
          want = spherical_due.pop_front();
          if (got.radius !== want.radius || got.lat !== want.lat ||
              got.lon !== want.lon) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp r=%0d lat=%0d lon=%0d got r=%0d lat=%0d lon=%0d",
                       $realtime, want.radius, want.lat, want.lon,
                       got.radius, got.lat, got.lon);
          end
        end
      end
    end
  end

  initial begin : stimulus
    coord_t mx;
    coord_t mn;
    coord_t x;
    coord_t y;
    coord_t z;
    int mode;
    mx = {1'b0, {(CB-1){1'b1}}};
    mn = {1'b1, {(CB-1){1'b0}}};

    // Zero vector, polar axis, the wrap at +pi and near-polar latitude clamping.
    add_pos(0, 0, 0);
    add_pos(0, 0, mx);
    add_pos(0, 0, mn);
    add_pos(0, 0, 1);
    add_pos(0, 0, -1);
    add_pos(mx, 0, 0);
    add_pos(mn, 0, 0);
    add_pos(-1, 0, 0);
    add_pos(-5, 0, 7);
    add_pos(0, mx, 0);
    add_pos(0, mn, 0);
    add_pos(mx, mx, mx);
    add_pos(mn, mn, mn);
    add_pos(mn, mx, mn);
    add_pos(1, 1, 1);
    add_pos(-1, -1, -1);
    add_pos(1, 0, mx);
    add_pos(0, 1, mn);
    add_pos(-1, 0, mx);
    add_pos(mn, 1, 0);
    add_pos(mn, -1, 0);
    add_pos(coord_t'(24'hAAAAAA), coord_t'(24'h555555), coord_t'(24'hAAAAAA));
    add_pos(coord_t'(24'h555555), coord_t'(24'hAAAAAA), coord_t'(24'h555555));
    n_directed = coords_pending.size();

    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(0, 9);
      if (mode <= 4) begin
        x = pick_coord(0); y = pick_coord(0); z = pick_coord(0);
      end else if (mode == 5) begin
        x = pick_coord(1); y = pick_coord(1); z = pick_coord(1);
      end else if (mode == 6) begin
        x = pick_coord(2); y = pick_coord(2); z = pick_coord(0);
      end else if (mode == 7) begin
        x = $urandom_range(0, 1) ? coord_t'(0) : pick_coord(0);
        y = $urandom_range(0, 1) ? coord_t'(0) : pick_coord(0);
        z = $urandom_range(0, 1) ? coord_t'(0) : pick_coord(0);
      end else if (mode == 8) begin
        // Left half plane close to the negative x axis, where the longitude wraps.
        x = -coord_t'($urandom_range(1, 1 << (CB - 1)));
        y = pick_coord(2);
        z = pick_coord($urandom_range(0, 1));
      end else begin
        x = pick_coord(3); y = pick_coord(3); z = pick_coord(3);
      end
      add_pos(x, y, z);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (coords_pending.size() != 0 || req_taken != req_offered) @(posedge clk);
    while (spherical_due.size() != 0) @(posedge clk);
    repeat (2 * STAGES + 20) @(posedge clk);
    if (spherical_due.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/c2s_pkg.sv
rtl/c2s_prep.sv
rtl/c2s_cell.sv
rtl/c2s_gain.sv
rtl/c2s_outq.sv
rtl/cartesian_to_spherical.sv
rtl/c2s_check.sv
bench/cartesian_to_spherical_tb.sv
